/* hdl/lnm_pkg.sv */
// ----------------------------------------------------------------------------
// lnm_pkg: shared types and constants for the linear NFA longest-match block
// Holds the item command codes, register indexes, fixed field widths and the
// structs that pass between the cell row and the top level.
// ----------------------------------------------------------------------------
package lnm_pkg;

	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int ROW_W      = 32;
	localparam int MATCH_W    = 16;
	localparam int PCOUNT_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_CHAR  = 2'd2,
		CMD_END   = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_MASK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK    = 2'd2;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic step;      // the item in stage one is retired this cycle
		cmd_t cmd;
		logic any_live;  // some pattern position is active after closure
	} cell_ctl_t;

	// Per-cell setup: what this place in the row is and what it matches.
	typedef struct packed {
		logic pos_en;  // a pattern position in use
		logic acc_en;  // the accept position
		logic skip;
		logic rep;
		logic row;     // class bit of the current byte
		logic head;    // first cell, seeded by a start item
	} cell_in_t;

	// Passed from one cell to its right-hand neighbor.
	typedef struct packed {
		logic close1;  // skip closure before the character
		logic hit;     // this position consumed the character
		logic close2;  // skip closure after the advance
	} cell_link_t;

	typedef struct packed {
		logic live;     // active pattern position after the first closure
		logic acc_hit;  // accept reached by this item
		logic alive;    // active pattern position reported in the result
		logic act;      // stored active bit
	} cell_stat_t;

endpackage

/* hdl/lnm_if.sv */
// ----------------------------------------------------------------------------
// lnm_if: handshake channels of the linear NFA longest-match block
// Input word channel, result word channel and register write channel, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------
interface lnm_in_if;
	logic                        valid;
	logic                        ready;
	logic [lnm_pkg::CMD_W-1:0]   cmd;
	logic [lnm_pkg::CHAR_W-1:0]  char_value;
	logic [lnm_pkg::ROW_W-1:0]   row_bits;

	modport source (output valid, cmd, char_value, row_bits, input ready);
	modport sink (input valid, cmd, char_value, row_bits, output ready);
endinterface

interface lnm_out_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [lnm_pkg::MATCH_W-1:0]  match_length;
	logic                         alive;
	logic                         finished;
	logic                         overflow;

	modport source (output valid, found, match_length, alive, finished, overflow,
		input ready);
	modport sink (input valid, found, match_length, alive, finished, overflow,
		output ready);
endinterface

interface lnm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lnm_pkg::CFG_IDX_W-1:0]   index;
	logic [lnm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/lnm_row_mem.sv */
// ----------------------------------------------------------------------------
// lnm_row_mem: class row memory
// One row per byte value; a load writes a row, a character reads one into a
// registered read port.
// ----------------------------------------------------------------------------
module lnm_row_mem #(
	parameter int DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    addr,
	input  logic [lnm_pkg::ROW_W-1:0]   wdata,
	output logic [lnm_pkg::ROW_W-1:0]   rdata
);

	logic [lnm_pkg::ROW_W-1:0] mem [DEPTH];
	logic [lnm_pkg::ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/lnm_cell.sv */
// ----------------------------------------------------------------------------
// lnm_cell: one place in the pattern chain
// Holds one active bit, closes over skippable neighbors on its left and takes
// the advance from the cell before it.
// ----------------------------------------------------------------------------
module lnm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lnm_pkg::cell_ctl_t   ctl,
	input  lnm_pkg::cell_in_t    cin,
	input  lnm_pkg::cell_link_t  link_in,
	output lnm_pkg::cell_link_t  link_out,
	output lnm_pkg::cell_stat_t  stat
);

	logic act_q;
	logic pre;
	logic hit;
	logic seed;
	logic post;
	logic in_chain;
	logic act_next;

	assign in_chain = cin.pos_en | cin.acc_en;

	// First closure over the stored vector, then the character advance,
	// then the second closure over the advanced vector.
	assign pre  = act_q | link_in.close1;
	assign hit  = pre & cin.row & cin.pos_en;
	assign seed = (ctl.cmd == lnm_pkg::CMD_START) ? cin.head
		: (link_in.hit | (hit & cin.rep));
	assign post = seed | link_in.close2;

	assign link_out.close1 = pre & cin.skip & cin.pos_en;
	assign link_out.hit    = hit;
	assign link_out.close2 = post & cin.skip & cin.pos_en;

	always_comb begin
		case (ctl.cmd)
			lnm_pkg::CMD_START: act_next = post & in_chain;
			lnm_pkg::CMD_CHAR:  act_next = ctl.any_live & post & in_chain;
			lnm_pkg::CMD_END:   act_next = 1'b0;
			default:            act_next = act_q;
		endcase
	end

	assign stat.live    = pre & cin.pos_en;
	assign stat.acc_hit = post & cin.acc_en;
	assign stat.alive   = ((ctl.cmd == lnm_pkg::CMD_END) ? act_q : act_next) & cin.pos_en;
	assign stat.act     = act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.step) begin
			act_q <= act_next;
		end
	end

endmodule

/* hdl/linear_nfa_longest_match_top.sv */
// The class row is read into stage one at the edge that accepts the input word, and the
// cell row update lands in the result register when stage one advances.
// Throughput: one input word per cycle while the result side keeps taking words;
// the row memory is read once per character word.
// Reset: the active vector, counters, flags, registers and handshakes clear at
// once; the class row memory is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// linear_nfa_longest_match_top: longest prefix match of a linear pattern
// A row of cells, one per pattern position plus the accept position, carries
// the active vector; a row memory holds the character class of each byte.
// ----------------------------------------------------------------------------
module linear_nfa_longest_match_top #(
	parameter int MAX_POSITIONS = 32,
	parameter int ALPHABET_SIZE = 256,
	parameter int LENGTH_BITS   = 16
) (
	input logic      clk,
	input logic      arst_n,
	lnm_in_if.sink   in_ch,
	lnm_out_if.source out_ch,
	lnm_cfg_if.sink  cfg
);

	localparam int AW     = $clog2(ALPHABET_SIZE);
	localparam int NCELLS = MAX_POSITIONS + 1;

	// Configuration registers. The write port never stalls.
	logic [lnm_pkg::PCOUNT_W-1:0] position_count_q;
	logic [lnm_pkg::ROW_W-1:0]    skip_mask_q;
	logic [lnm_pkg::ROW_W-1:0]    repeat_mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_count_q <= '0;
			skip_mask_q      <= '0;
			repeat_mask_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				lnm_pkg::REG_POSITION_COUNT: position_count_q <= cfg.data[lnm_pkg::PCOUNT_W-1:0];
				lnm_pkg::REG_SKIP_MASK:      skip_mask_q      <= cfg.data;
				lnm_pkg::REG_REPEAT_MASK:    repeat_mask_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Positions in use; counts above the row length act as the row length.
	logic [lnm_pkg::PCOUNT_W-1:0] used_n;
	assign used_n = (position_count_q > lnm_pkg::PCOUNT_W'(MAX_POSITIONS))
		? lnm_pkg::PCOUNT_W'(MAX_POSITIONS) : position_count_q;

	// Stage one: the accepted word waits here while its class row is read.
	// A load writes the memory at acceptance, so a character right behind it
	// already reads the new row.
	logic          valid_s1;
	lnm_pkg::cmd_t cmd_s1;
	logic          in_range_s1;
	logic          advance;
	logic          in_fire;
	logic          in_range;
	lnm_pkg::cmd_t in_cmd;
	logic [lnm_pkg::ROW_W-1:0] row_s1;

	assign in_cmd   = lnm_pkg::cmd_t'(in_ch.cmd);
	assign in_range = {1'b0, in_ch.char_value} < (lnm_pkg::CHAR_W + 1)'(ALPHABET_SIZE);

	// Stage one moves on when the result register is empty or being drained.
	logic out_valid_q;
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	lnm_row_mem #(
		.DEPTH (ALPHABET_SIZE)
	) u_row_mem (
		.clk   (clk),
		.we    (in_fire && in_cmd == lnm_pkg::CMD_LOAD && in_range),
		.re    (in_fire && in_cmd == lnm_pkg::CMD_CHAR),
		.addr  (in_ch.char_value[AW-1:0]),
		.wdata (in_ch.row_bits),
		.rdata (row_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1      <= in_cmd;
			in_range_s1 <= in_range;
		end
	end

	// The cell row. Cell i is pattern position i while i is below the count,
	// and the cell at the count is the accept position; cells beyond it idle.
	lnm_pkg::cell_ctl_t  ctl;
	lnm_pkg::cell_in_t   cell_in  [NCELLS];
	lnm_pkg::cell_link_t link     [NCELLS+1];
	lnm_pkg::cell_stat_t stat     [NCELLS];
	logic [NCELLS-1:0]   live_vec;
	logic [NCELLS-1:0]   acc_vec;
	logic [NCELLS-1:0]   alive_vec;
	logic [NCELLS-1:0]   act_vec;
	logic [NCELLS-1:0]   acc_en_vec;

	assign link[0] = '0;

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		logic skip_b;
		logic rep_b;
		logic row_b;

		if (i < lnm_pkg::ROW_W) begin : g_mapped
			assign skip_b = skip_mask_q[i];
			assign rep_b  = repeat_mask_q[i];
			assign row_b  = row_s1[i] & in_range_s1;
		end else begin : g_unmapped
			assign skip_b = 1'b0;
			assign rep_b  = 1'b0;
			assign row_b  = 1'b0;
		end

		assign cell_in[i].pos_en = lnm_pkg::PCOUNT_W'(i) < used_n;
		assign cell_in[i].acc_en = lnm_pkg::PCOUNT_W'(i) == used_n;
		assign cell_in[i].skip   = skip_b;
		assign cell_in[i].rep    = rep_b;
		assign cell_in[i].row    = row_b;
		assign cell_in[i].head   = (i == 0);

		lnm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cin      (cell_in[i]),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.stat     (stat[i])
		);

		assign live_vec[i]   = stat[i].live;
		assign acc_vec[i]    = stat[i].acc_hit;
		assign alive_vec[i]  = stat[i].alive;
		assign act_vec[i]    = stat[i].act;
		assign acc_en_vec[i] = cell_in[i].acc_en;
	end

	// The closure chain past the accept cell carries nothing further.
	logic chain_tail_unused;
	assign chain_tail_unused = ^link[NCELLS];

	assign ctl.step     = advance;
	assign ctl.cmd      = cmd_s1;
	assign ctl.any_live = |live_vec;

	// Match bookkeeping: characters consumed since start, longest accepted
	// length, and the found and overflow flags. The count saturates.
	logic [LENGTH_BITS-1:0] consumed_q, consumed_n;
	logic [LENGTH_BITS-1:0] best_q, best_n;
	logic                   found_q, found_n;
	logic                   overflow_q, overflow_n;
	logic                   sat;
	logic                   acc_hit;

	assign sat     = &consumed_q;
	assign acc_hit = |acc_vec;

	always_comb begin
		consumed_n = consumed_q;
		best_n     = best_q;
		found_n    = found_q;
		overflow_n = overflow_q;
		case (cmd_s1)
			lnm_pkg::CMD_START: begin
				consumed_n = '0;
				best_n     = '0;
				found_n    = acc_hit;
				overflow_n = 1'b0;
			end
			lnm_pkg::CMD_CHAR: begin
				if (ctl.any_live) begin
					if (sat) begin
						overflow_n = 1'b1;
					end else begin
						consumed_n = consumed_q + 1'b1;
					end
					if (acc_hit) begin
						found_n = 1'b1;
						best_n  = consumed_n;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			overflow_q <= 1'b0;
		end else if (advance) begin
			consumed_q <= consumed_n;
			best_q     <= best_n;
			found_q    <= found_n;
			overflow_q <= overflow_n;
		end
	end

	// Reported length is zero until something was found, then fitted to the
	// result field.
	logic [LENGTH_BITS-1:0]      len_w;
	logic [lnm_pkg::MATCH_W-1:0] len_out;
	assign len_w = found_n ? best_n : '0;

	if (LENGTH_BITS >= lnm_pkg::MATCH_W) begin : g_len_trunc
		assign len_out = len_w[lnm_pkg::MATCH_W-1:0];
	end else begin : g_len_ext
		assign len_out = {{(lnm_pkg::MATCH_W-LENGTH_BITS){1'b0}}, len_w};
	end

	// Result register: it takes a new word whenever stage one retires one; while
	// a finished word waits to be taken, stage one holds and the input stalls.
	logic                        found_out_q;
	logic [lnm_pkg::MATCH_W-1:0] length_out_q;
	logic                        alive_out_q;
	logic                        finished_out_q;
	logic                        overflow_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_out_q    <= found_n;
			length_out_q   <= len_out;
			alive_out_q    <= |alive_vec;
			finished_out_q <= (cmd_s1 == lnm_pkg::CMD_END);
			overflow_out_q <= overflow_n;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = found_out_q;
	assign out_ch.match_length = length_out_q;
	assign out_ch.alive        = alive_out_q;
	assign out_ch.finished     = finished_out_q;
	assign out_ch.overflow     = overflow_out_q ^ (chain_tail_unused & 1'b0);

	// Exactly one cell plays the accept position for any register setting.
	a_one_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(acc_en_vec))
		else $error("accept position is not unique");

	// Nothing stays active once an end word has been retired.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == lnm_pkg::CMD_END) |=> (act_vec == '0))
		else $error("active vector not cleared by end word");

	// Overflow is only ever raised with the character count at its limit.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> sat)
		else $error("overflow flag without saturated count");

	// A best length exists only together with the found flag.
	a_best_found: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> (best_q == '0))
		else $error("best length set without a match");

endmodule

/* tb/sv/linear_nfa_longest_match_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_nfa_longest_match_top_tb: self-checking bench for the longest-match block
// Feeds load, start, character and end words with random pacing on both sides.
// An in-bench copy of the matcher predicts every result word. The monitor
// compares the results field by field, in order.
// ----------------------------------------------------------------------------
module linear_nfa_longest_match_top_tb;

	// One input word and one result word as the bench sees them.
	typedef struct packed {
		lnm_pkg::cmd_t                cmd;
		logic [lnm_pkg::CHAR_W-1:0]   char_value;
		logic [lnm_pkg::ROW_W-1:0]    row_bits;
	} scan_word_t;

	typedef struct packed {
		logic                         found;
		logic [lnm_pkg::MATCH_W-1:0]  match_length;
		logic                         alive;
		logic                         finished;
		logic                         overflow;
	} match_result_t;

	localparam int RECEIVER_HOLD_CYCLES = 80;
	localparam int SCAN_PHASES = 12;
	localparam int WORDS_PER_PHASE = 130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lnm_in_if  in_ch();
	lnm_out_if out_ch();
	lnm_cfg_if cfg_ch();

	linear_nfa_longest_match_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Matcher copy used for prediction. It mirrors the block's registers, the
	// class row memory and the active vector. Bit n of the vector is the
	// accept position when n positions are in use.
	// ------------------------------------------------------------------------
	logic [lnm_pkg::PCOUNT_W-1:0] pos_used_reg = '0;
	logic [lnm_pkg::ROW_W-1:0]    skip_bits = '0;
	logic [lnm_pkg::ROW_W-1:0]    repeat_bits = '0;
	logic [lnm_pkg::ROW_W-1:0]    row_table [256];
	logic [32:0]                  active_vec = '0;
	logic [lnm_pkg::MATCH_W-1:0]  char_count = '0;
	logic [lnm_pkg::MATCH_W-1:0]  best_len = '0;
	logic                         hit_seen = 1'b0;
	logic                         sat_seen = 1'b0;

	scan_word_t          pending_words[$];
	match_result_t       expected_results[$];
	int                  fail_count = 0;

	// Pacing controls for the feed and the result side; idle_mode is shared by both.
	logic                idle_mode = 1'b0;
	logic                hold_go = 1'b0;
	logic                sink_hold = 1'b0;

	// Spread activity across every skippable position that is reachable from
	// an active one. Walking upward lets a chain of skips close in one pass.
	function automatic logic [32:0] close_skips(input logic [32:0] vec, input int n);
		for (int i = 0; i < n; i++) begin
			if (vec[i] && skip_bits[i])
				vec[i+1] = 1'b1;
		end
		return vec;
	endfunction

	// Apply one accepted word to the matcher copy and return its result word.
	function automatic match_result_t advance_matcher(input scan_word_t w);
		int            n;
		logic [32:0]   live_mask;
		logic [32:0]   closed;
		logic [32:0]   hit;
		logic [32:0]   nxt;
		logic          done;
		match_result_t r;

		// Counts beyond the row width behave as a full row.
		n = (pos_used_reg > 6'd32) ? 32 : int'(pos_used_reg);
		live_mask = (33'd1 << n) - 33'd1;
		done = 1'b0;

		case (w.cmd)
			lnm_pkg::CMD_LOAD: begin
				row_table[w.char_value] = w.row_bits;
			end
			lnm_pkg::CMD_START: begin
				char_count = '0;
				best_len = '0;
				hit_seen = 1'b0;
				sat_seen = 1'b0;
				active_vec = close_skips(33'd1, n);
				// The empty prefix counts when accept is reachable at once.
				if (active_vec[n])
					hit_seen = 1'b1;
			end
			lnm_pkg::CMD_CHAR: begin
				closed = close_skips(active_vec, n);
				if ((closed & live_mask) != '0) begin
					hit = closed & {1'b0, row_table[w.char_value]} & live_mask;
					nxt = (hit << 1) | (hit & {1'b0, repeat_bits});
					// The count sticks at its top value and flags overflow.
					if (char_count == {lnm_pkg::MATCH_W{1'b1}})
						sat_seen = 1'b1;
					else
						char_count++;
					nxt = close_skips(nxt, n);
					if (nxt[n]) begin
						hit_seen = 1'b1;
						best_len = char_count;
					end
					active_vec = nxt;
				end else begin
					// A dead match stays dead until the next start.
					active_vec = '0;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase

		r.found = hit_seen;
		r.match_length = hit_seen ? best_len : '0;
		r.alive = ((active_vec & live_mask) != '0);
		r.finished = done;
		r.overflow = sat_seen;
		// End of text reports the state first and only then clears the vector.
		if (done)
			active_vec = '0;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Input side. The falling-edge block puts the next word on the channel
	// after a random gap; the rising-edge block notes the handshake and runs
	// the prediction for the word that was taken.
	// ------------------------------------------------------------------------
	scan_word_t cur_word;
	logic       word_taken = 1'b0;
	logic       feed_busy = 1'b0;
	int         gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			word_taken = 1'b1;
			expected_results.push_back(advance_matcher(cur_word));
		end
	end

	always @(negedge clk) begin
		if (word_taken) begin
			word_taken = 1'b0;
			feed_busy = 1'b0;
			gap_left = idle_mode ? $urandom_range(0, 4) : 0;
		end
		// While a word is offered it stays on the channel untouched, so valid
		// gets at most one assignment in any step.
		if (!feed_busy) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				cur_word = pending_words.pop_front();
				in_ch.cmd <= cur_word.cmd;
				in_ch.char_value <= cur_word.char_value;
				in_ch.row_bits <= cur_word.row_bits;
				in_ch.valid <= 1'b1;
				feed_busy = 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result side. Every result word taken at a rising edge is checked against
	// the oldest prediction. Ready is paced at the falling edge with a random
	// stall per word, and it drops for the whole of a long hold.
	// ------------------------------------------------------------------------
	logic result_taken = 1'b0;
	int   stall_left = 0;

	task automatic flag_mismatch(input string field,
		input logic [lnm_pkg::MATCH_W-1:0] want_v,
		input logic [lnm_pkg::MATCH_W-1:0] got_v);
		fail_count++;
		$error("%s: expected %0h, got %0h", field, want_v, got_v);
	endtask

	always @(posedge clk) begin : result_check
		match_result_t want;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			result_taken = 1'b1;
			if (expected_results.size() == 0) begin
				fail_count++;
				$error("result word arrived with no prediction waiting");
			end else begin
				want = expected_results.pop_front();
				if (out_ch.found !== want.found)
					flag_mismatch("found", 16'(want.found), 16'(out_ch.found));
				if (out_ch.match_length !== want.match_length)
					flag_mismatch("match_length", want.match_length, out_ch.match_length);
				if (out_ch.alive !== want.alive)
					flag_mismatch("alive", 16'(want.alive), 16'(out_ch.alive));
				if (out_ch.finished !== want.finished)
					flag_mismatch("finished", 16'(want.finished), 16'(out_ch.finished));
				if (out_ch.overflow !== want.overflow)
					flag_mismatch("overflow", 16'(want.overflow), 16'(out_ch.overflow));
			end
		end
	end

	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 1'b0;
			stall_left = idle_mode ? $urandom_range(0, 4) : 0;
		end
		if (sink_hold) begin
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Long receiver hold, counted here while the feed keeps offering words,
	// so the pipeline fills and the block has to stall its input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		sink_hold = 1'b1;
		repeat (RECEIVER_HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// Fixed time limit; a hung handshake ends the run here.
	initial begin
		#100_000_000;
		$display("** linear_nfa_longest_match_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_word(input lnm_pkg::cmd_t c,
		input logic [lnm_pkg::CHAR_W-1:0] ch,
		input logic [lnm_pkg::ROW_W-1:0] bits);
		scan_word_t w;

		w.cmd = c;
		w.char_value = ch;
		w.row_bits = bits;
		pending_words.push_back(w);
	endtask

	// Registers change only here, on a handshake of the write channel, and the
	// matcher copy follows at the same edge.
	task automatic write_reg(input logic [lnm_pkg::CFG_IDX_W-1:0] idx,
		input logic [lnm_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			lnm_pkg::REG_POSITION_COUNT: pos_used_reg = val[lnm_pkg::PCOUNT_W-1:0];
			lnm_pkg::REG_SKIP_MASK: skip_bits = val;
			lnm_pkg::REG_REPEAT_MASK: repeat_bits = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every queued word is in and every result word is out, then
	// give the pipeline some slack.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || feed_busy || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Class rows of mixed density; dense rows let matches run deeper.
	function automatic logic [lnm_pkg::ROW_W-1:0] pick_row();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return $urandom | $urandom;
		endcase
	endfunction

	function automatic logic [lnm_pkg::ROW_W-1:0] pick_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom & $urandom;
		endcase
	endfunction

	// Mostly short counts so that matches reach accept; sometimes a full row
	// or a count above the row width.
	function automatic logic [lnm_pkg::PCOUNT_W-1:0] pick_pcount();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd32;
			2: return 6'($urandom_range(33, 63));
			3: return 6'd1;
			default: return 6'($urandom_range(2, 8));
		endcase
	endfunction

	// A phase is mostly whole matches (start, characters, end) with random
	// bytes, with row reloads and stray words of any kind mixed in. Ignored
	// fields carry random values too.
	task automatic queue_scan_phase(input int target);
		int made;
		int pick;
		int run_len;

		made = 0;
		while (made < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				queue_word(lnm_pkg::CMD_START, 8'($urandom_range(0, 255)), $urandom);
				run_len = $urandom_range(0, 16);
				repeat (run_len)
					queue_word(lnm_pkg::CMD_CHAR, 8'($urandom_range(0, 255)), $urandom);
				made += run_len + 1;
				// Some matches are left open and cut off by the next start.
				if ($urandom_range(0, 9) != 0) begin
					queue_word(lnm_pkg::CMD_END, 8'($urandom_range(0, 255)), $urandom);
					made++;
				end
			end else if (pick < 88) begin
				queue_word(lnm_pkg::CMD_LOAD, 8'($urandom_range(0, 255)), pick_row());
				made++;
			end else begin
				queue_word(lnm_pkg::cmd_t'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), $urandom);
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = lnm_pkg::CMD_LOAD;
		in_ch.char_value = '0;
		in_ch.row_bits = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = lnm_pkg::REG_POSITION_COUNT;
		cfg_ch.data = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_idle();

		// Directed part. Pattern: 'a', optional 'b', then 'c' repeated.
		idle_mode = 1'b1;
		write_reg(lnm_pkg::REG_POSITION_COUNT, 32'd3);
		write_reg(lnm_pkg::REG_SKIP_MASK, 32'h0000_0002);
		write_reg(lnm_pkg::REG_REPEAT_MASK, 32'h0000_0004);
		// Every byte used below gets its row first; byte 0x00 matches nothing
		// and byte 0xff matches every position.
		queue_word(lnm_pkg::CMD_LOAD, 8'h00, 32'h0000_0000);
		queue_word(lnm_pkg::CMD_LOAD, 8'hff, 32'hffff_ffff);
		queue_word(lnm_pkg::CMD_LOAD, 8'h61, 32'h0000_0001);
		queue_word(lnm_pkg::CMD_LOAD, 8'h62, 32'h0000_0002);
		queue_word(lnm_pkg::CMD_LOAD, 8'h63, 32'h0000_0004);
		// Characters and an end before any start change nothing.
		queue_word(lnm_pkg::CMD_CHAR, 8'h61, '0);
		queue_word(lnm_pkg::CMD_END, 8'h00, '0);
		// "abccc" is accepted at lengths 3, 4 and 5.
		queue_word(lnm_pkg::CMD_START, 8'h00, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h61, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h62, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h63, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h63, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h63, '0);
		queue_word(lnm_pkg::CMD_END, 8'h00, '0);
		// "ac" skips the optional 'b'; 0xff extends it, 0x00 kills the match,
		// and the next character finds nothing active.
		queue_word(lnm_pkg::CMD_START, 8'h00, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h61, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h63, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'hff, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h00, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h61, '0);
		queue_word(lnm_pkg::CMD_END, 8'h00, '0);
		// A second end sees the vector already cleared.
		queue_word(lnm_pkg::CMD_END, 8'h00, '0);
		wait_idle();

		// With every position skippable the empty prefix is a match.
		write_reg(lnm_pkg::REG_SKIP_MASK, 32'h0000_0007);
		queue_word(lnm_pkg::CMD_START, 8'h00, '0);
		queue_word(lnm_pkg::CMD_CHAR, 8'h00, '0);
		queue_word(lnm_pkg::CMD_END, 8'h00, '0);

		// Random part, one register setting per phase. Every third phase runs
		// with no idling on either side.
		for (int ph = 0; ph < SCAN_PHASES; ph++) begin
			wait_idle();
			idle_mode = (ph % 3 != 0);
			case (ph)
				0: begin
					write_reg(lnm_pkg::REG_POSITION_COUNT, {26'($urandom), 6'd32});
					write_reg(lnm_pkg::REG_SKIP_MASK, '1);
					write_reg(lnm_pkg::REG_REPEAT_MASK, '1);
				end
				1: begin
					write_reg(lnm_pkg::REG_POSITION_COUNT, {26'($urandom), 6'd63});
					write_reg(lnm_pkg::REG_SKIP_MASK, '0);
					write_reg(lnm_pkg::REG_REPEAT_MASK, '0);
				end
				2: begin
					write_reg(lnm_pkg::REG_POSITION_COUNT, {26'($urandom), 6'd0});
					write_reg(lnm_pkg::REG_SKIP_MASK, pick_mask());
					write_reg(lnm_pkg::REG_REPEAT_MASK, pick_mask());
				end
				default: begin
					write_reg(lnm_pkg::REG_POSITION_COUNT, {26'($urandom), pick_pcount()});
					write_reg(lnm_pkg::REG_SKIP_MASK, pick_mask());
					write_reg(lnm_pkg::REG_REPEAT_MASK, pick_mask());
				end
			endcase
			// Fill the whole row memory once, so any byte is safe to send.
			if (ph == 0) begin
				for (int b = 0; b < 256; b++)
					queue_word(lnm_pkg::CMD_LOAD, 8'(b), pick_row());
			end
			if (ph == 4)
				hold_go = 1'b1;
			queue_scan_phase(WORDS_PER_PHASE);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			fail_count++;
			$error("%0d result words never arrived", expected_results.size());
		end
		if (fail_count == 0)
			$display("** linear_nfa_longest_match_top: PASSED **");
		else
			$display("** linear_nfa_longest_match_top: FAILED **");
		$finish;
	end

endmodule
